>>> sv/abc_pkg.sv
// Shared constants and types for the add-and-branch-on-carry core.
package abc_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int PC_W          = 32;
  localparam int CELL_W        = 8;
  localparam int INSTR_BYTES   = 6;

  localparam logic [FIELD_W-1:0] HALT_TARGET = 16'h7FFF;
  localparam logic [CELL_W-1:0]  CELL_ONE    = 8'h01;

  typedef enum logic {
    REQ_EXEC = 1'b0,
    REQ_READ = 1'b1
  } req_t;

endpackage

>>> sv/abc_if.sv
// Valid/ready channel interfaces for request and result words.
interface abc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [abc_pkg::FIELD_W-1:0] dest_addr;
  logic [abc_pkg::FIELD_W-1:0] src_addr;
  logic [abc_pkg::FIELD_W-1:0] jump_target;
  logic [abc_pkg::FIELD_W-1:0] read_addr;

  modport source (output valid, req_type, dest_addr, src_addr, jump_target, read_addr,
                  input ready);
  modport sink   (input valid, req_type, dest_addr, src_addr, jump_target, read_addr,
                  output ready);
endinterface

interface abc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       branch_taken;
  logic                       halted;
  logic [abc_pkg::PC_W-1:0]   next_pc;
  logic [abc_pkg::CELL_W-1:0] cell_value;

  modport source (output valid, branch_taken, halted, next_pc, cell_value, input ready);
  modport sink   (input valid, branch_taken, halted, next_pc, cell_value, output ready);
endinterface

>>> sv/abc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module abc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/abc_clear.sv
// Post-reset sweep that writes the initial value into every cell.
module abc_clear #(
  parameter int ADDR_BITS = abc_pkg::ADDR_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  output logic                       clr_busy,
  output logic [ADDR_BITS-1:0]       clr_addr,
  output logic [abc_pkg::CELL_W-1:0] clr_data
);

  logic                 busy_r, busy_nxt;
  logic [ADDR_BITS-1:0] cnt_r, cnt_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (busy_r) begin
      cnt_nxt = cnt_r + ADDR_BITS'(1);
      if (cnt_r == {ADDR_BITS{1'b1}}) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign clr_busy = busy_r;
  assign clr_addr = cnt_r;
  assign clr_data = (cnt_r == ADDR_BITS'(1)) ? abc_pkg::CELL_ONE : '0;

endmodule

>>> sv/add_branch_on_carry_core.sv
// Top level of the add-and-branch-on-carry core: cell store, execute stage and result register.
// Execute stage register, then result register. Throughput: one word per cycle while the result
// side does not stall; the execute stage reads both operands from two duplicated cell RAMs and
// forwards the write made at the edge of its own read.
// Reset: synchronous; afterwards a sweep writes all 2^ADDR_BITS cells, one per cycle,
// and no request word is accepted until it ends.
module add_branch_on_carry_core #(
  parameter int ADDR_BITS = abc_pkg::ADDR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  abc_in_if.sink           in_ch,
  abc_out_if.source        out_ch
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic                       clr_busy;
  logic [ADDR_BITS-1:0]       clr_addr;
  logic [abc_pkg::CELL_W-1:0] clr_data;

  logic                       in_accept;
  logic                       s1_fire;

  logic                       s1_valid_r, s1_valid_nxt;
  logic                       s1_req_r;
  logic                       s1_halt_r;
  logic [ADDR_BITS-1:0]       s1_a_addr_r;
  logic [ADDR_BITS-1:0]       s1_b_addr_r;
  logic [abc_pkg::FIELD_W-1:0] s1_target_r;

  logic                       fwd_valid_r;
  logic [ADDR_BITS-1:0]       fwd_addr_r;
  logic [abc_pkg::CELL_W-1:0] fwd_data_r;

  logic                       halt_r, halt_nxt;
  logic [abc_pkg::PC_W-1:0]   pc_r, pc_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_taken_r;
  logic                       out_halted_r;
  logic [abc_pkg::PC_W-1:0]   out_pc_r;
  logic [abc_pkg::CELL_W-1:0] out_value_r;

  logic [ADDR_BITS-1:0]       rd_a_addr;
  logic [abc_pkg::CELL_W-1:0] ram_a_rdata, ram_b_rdata;
  logic [abc_pkg::CELL_W-1:0] a_val, b_val, s_val, sum;
  logic                       same_cell, taken, exec_live, wr_en;
  logic                       mem_we;
  logic [ADDR_BITS-1:0]       mem_waddr;
  logic [abc_pkg::CELL_W-1:0] mem_wdata;

  abc_clear #(.ADDR_BITS(ADDR_BITS)) u_clear (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_busy (clr_busy),
    .clr_addr (clr_addr),
    .clr_data (clr_data)
  );

  assign s1_fire      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !clr_busy && (!s1_valid_r || s1_fire);
  assign in_accept    = in_ch.valid && in_ch.ready;

  assign rd_a_addr = (in_ch.req_type == abc_pkg::REQ_READ) ?
                     in_ch.read_addr[ADDR_BITS-1:0] : in_ch.dest_addr[ADDR_BITS-1:0];

  assign mem_we    = clr_busy || wr_en;
  assign mem_waddr = clr_busy ? clr_addr : s1_a_addr_r;
  assign mem_wdata = clr_busy ? clr_data : sum;

  abc_ram #(.WIDTH(abc_pkg::CELL_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (rd_a_addr),
    .rdata (ram_a_rdata)
  );

  abc_ram #(.WIDTH(abc_pkg::CELL_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_accept),
    .raddr (in_ch.src_addr[ADDR_BITS-1:0]),
    .rdata (ram_b_rdata)
  );

  // The RAM returns old data when a cell is written at the edge of its read.
  always_comb begin
    a_val     = (fwd_valid_r && fwd_addr_r == s1_a_addr_r) ? fwd_data_r : ram_a_rdata;
    b_val     = (fwd_valid_r && fwd_addr_r == s1_b_addr_r) ? fwd_data_r : ram_b_rdata;
    same_cell = (s1_a_addr_r == s1_b_addr_r);
    s_val     = same_cell ? a_val : b_val;
    sum       = a_val + s_val;
    taken     = !same_cell && (sum < s_val);
    exec_live = (s1_req_r == abc_pkg::REQ_EXEC) && !halt_r && !s1_halt_r;
    wr_en     = s1_fire && exec_live;
  end

  always_comb begin
    halt_nxt = halt_r;
    pc_nxt   = pc_r;
    if (s1_fire && (s1_req_r == abc_pkg::REQ_EXEC) && !halt_r) begin
      if (s1_halt_r) begin
        halt_nxt = 1'b1;
      end else if (taken) begin
        pc_nxt = {{(abc_pkg::PC_W - abc_pkg::FIELD_W){1'b0}}, s1_target_r};
      end else begin
        pc_nxt = pc_r + abc_pkg::PC_W'(abc_pkg::INSTR_BYTES);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_valid_r <= 1'b0;
      halt_r      <= 1'b0;
      pc_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      halt_r      <= halt_nxt;
      pc_r        <= pc_nxt;
      if (in_accept) begin
        fwd_valid_r <= wr_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r    <= in_ch.req_type;
      s1_halt_r   <= (in_ch.dest_addr == '0) && (in_ch.src_addr == '0) &&
                     (in_ch.jump_target == abc_pkg::HALT_TARGET);
      s1_a_addr_r <= rd_a_addr;
      s1_b_addr_r <= in_ch.src_addr[ADDR_BITS-1:0];
      s1_target_r <= in_ch.jump_target;
      fwd_addr_r  <= s1_a_addr_r;
      fwd_data_r  <= sum;
    end
    if (s1_fire) begin
      out_taken_r  <= wr_en && taken;
      out_halted_r <= halt_nxt;
      out_pc_r     <= pc_nxt;
      out_value_r  <= (s1_req_r == abc_pkg::REQ_READ) ? a_val : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.branch_taken = out_taken_r;
  assign out_ch.halted       = out_halted_r;
  assign out_ch.next_pc      = out_pc_r;
  assign out_ch.cell_value   = out_value_r;

endmodule

>>> sv/abc_checker.sv
// Port-level checks for the add-and-branch-on-carry core and their binding.
module abc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_branch_taken,
  input logic                       out_halted,
  input logic [abc_pkg::PC_W-1:0]   out_next_pc,
  input logic [abc_pkg::CELL_W-1:0] out_cell_value
);

  logic seen_halt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_halt_r <= 1'b0;
    end else if (out_valid && out_ready && out_halted) begin
      seen_halt_r <= 1'b1;
    end
  end

  // The cell sweep after reset keeps the request side closed.
  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request ready right after reset");

  a_taken_not_halted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_branch_taken |-> !out_halted)
    else $error("branch reported by a halted core");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_halt_r |-> out_halted)
    else $error("halted flag dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_next_pc) && $stable(out_cell_value))
    else $error("stalled result word changed");

endmodule

bind add_branch_on_carry_core abc_checker u_abc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_branch_taken (out_ch.branch_taken),
  .out_halted       (out_ch.halted),
  .out_next_pc      (out_ch.next_pc),
  .out_cell_value   (out_ch.cell_value)
);

>>> tb/add_branch_on_carry_core_tb.sv
// Self-checking testbench for the add-and-branch-on-carry core: directed and random request words.
module add_branch_on_carry_core_tb;
  import abc_pkg::*;

  typedef struct packed {
    req_t               kind;
    logic [FIELD_W-1:0] dest;
    logic [FIELD_W-1:0] src;
    logic [FIELD_W-1:0] target;
    logic [FIELD_W-1:0] raddr;
  } core_req_t;

  typedef struct packed {
    logic              taken;
    logic              halted;
    logic [PC_W-1:0]   pc;
    logic [CELL_W-1:0] value;
  } core_rsp_t;

  localparam int CELLS            = 1 << ADDR_BITS_DEF;
  localparam int IDLE_LIMIT       = 200000;
  localparam int RANDOM_PER_PHASE = 460;
  localparam int DRAIN_CYCLES     = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  abc_in_if  in_ch ();
  abc_out_if out_ch ();

  add_branch_on_carry_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  logic [CELL_W-1:0] cell_mem [CELLS];
  logic [PC_W-1:0]   pc_reg    = '0;
  logic              halt_seen = 1'b0;

  core_req_t request_q[$];
  core_rsp_t expected_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int idle_cycles    = 0;

  // Applies one request word to the local copy of the core state.
  function automatic core_rsp_t execute_request(core_req_t r);
    core_rsp_t rsp;
    rsp = '0;
    if (r.kind == REQ_READ) begin
      rsp.value = cell_mem[r.raddr];
    end else if (!halt_seen) begin
      if (r.dest == '0 && r.src == '0 && r.target == HALT_TARGET) begin
        halt_seen = 1'b1;
      end else begin
        cell_mem[r.dest] = cell_mem[r.dest] + cell_mem[r.src];
        if (cell_mem[r.dest] < cell_mem[r.src]) begin
          pc_reg    = PC_W'(r.target);
          rsp.taken = 1'b1;
        end else begin
          pc_reg = pc_reg + PC_W'(INSTR_BYTES);
        end
      end
    end
    rsp.halted = halt_seen;
    rsp.pc     = pc_reg;
    return rsp;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_cell();
    int sel;
    sel = $urandom_range(19);
    if (sel == 0) return FIELD_W'($urandom);
    else if (sel < 4) return 16'hFFF8 | FIELD_W'($urandom_range(7));
    else return FIELD_W'($urandom_range(7));
  endfunction

  task automatic push_exec(logic [FIELD_W-1:0] d, logic [FIELD_W-1:0] s,
                           logic [FIELD_W-1:0] t);
    request_q.push_back('{kind: REQ_EXEC, dest: d, src: s, target: t,
                          raddr: FIELD_W'($urandom)});
  endtask

  task automatic push_read(logic [FIELD_W-1:0] a);
    request_q.push_back('{kind: REQ_READ, dest: FIELD_W'($urandom), src: FIELD_W'($urandom),
                          target: FIELD_W'($urandom), raddr: a});
  endtask

  function automatic core_req_t random_request();
    core_req_t r;
    r.dest   = pick_cell();
    r.src    = pick_cell();
    r.raddr  = pick_cell();
    r.target = ($urandom_range(9) == 0) ? HALT_TARGET : FIELD_W'($urandom);
    if ($urandom_range(9) < 7) begin
      r.kind = REQ_EXEC;
      // The halt word is kept for the closing part of the run.
      if (r.dest == '0 && r.src == '0 && r.target == HALT_TARGET) r.target = 16'h7FFE;
    end else begin
      r.kind = REQ_READ;
    end
    return r;
  endfunction

  task automatic finish_phase();
    while (request_q.size() != 0 || expected_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    logic fire;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        expected_q.push_back(execute_request(request_q.pop_front()));
      end
      if (in_ch.valid && !fire) begin
        // The current word is held until it is taken.
      end else if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= request_q[0].kind;
        in_ch.dest_addr   <= request_q[0].dest;
        in_ch.src_addr    <= request_q[0].src;
        in_ch.jump_target <= request_q[0].target;
        in_ch.read_addr   <= request_q[0].raddr;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    core_rsp_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result word with none expected: taken=%0b halted=%0b pc=%h value=%h",
                   out_ch.branch_taken, out_ch.halted, out_ch.next_pc, out_ch.cell_value);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.branch_taken !== want.taken || out_ch.halted !== want.halted ||
            out_ch.next_pc !== want.pc || out_ch.cell_value !== want.value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected taken=%0b halted=%0b pc=%h value=%h, got %0b %0b %h %h",
                     want.taken, want.halted, want.pc, want.value, out_ch.branch_taken,
                     out_ch.halted, out_ch.next_pc, out_ch.cell_value);
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.req_type    = REQ_EXEC;
    in_ch.dest_addr   = '0;
    in_ch.src_addr    = '0;
    in_ch.jump_target = '0;
    in_ch.read_addr   = '0;
    out_ch.ready      = 1'b0;
    for (int i = 0; i < CELLS; i++) cell_mem[i] = '0;
    cell_mem[1] = CELL_ONE;

    push_read(16'h0000);
    push_read(16'h0001);
    push_read(16'hFFFF);
    push_exec(16'h0001, 16'h0001, 16'h1234);
    push_exec(16'h0002, 16'h0001, 16'hFFFF);
    repeat (6) push_exec(16'h0001, 16'h0001, 16'h0000);
    push_exec(16'h0003, 16'h0001, 16'hFFFF);
    push_exec(16'h0003, 16'h0001, 16'hFFFF);
    push_exec(16'hFFFF, 16'h0003, 16'h0000);
    push_exec(16'h0001, 16'h0001, 16'h0000);
    push_read(16'h0003);
    push_read(16'h0001);
    push_exec(16'h0000, 16'h0000, 16'h7FFE);
    push_exec(16'h0000, 16'h0002, HALT_TARGET);
    push_exec(16'h0002, 16'h0000, HALT_TARGET);
    push_read(16'h0000);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    finish_phase();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = (p == 1) ? 61 : (p == 3) ? 38 : 0;
      recv_stall_pct = (p == 2) ? 61 : (p == 3) ? 38 : 0;
      repeat (RANDOM_PER_PHASE) request_q.push_back(random_request());
      finish_phase();
    end

    // Once halted, executes change nothing while reads are still served.
    push_exec(16'h0000, 16'h0000, HALT_TARGET);
    push_exec(16'h0001, 16'h0002, 16'h0010);
    push_read(16'h0002);
    push_exec(16'h0000, 16'h0000, HALT_TARGET);
    push_read(16'h0001);
    finish_phase();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
